// File: design/unique_value_list_table_defines.svh
// Assertion macros shared by the unique value list table RTL.
`ifndef UNIQUE_VALUE_LIST_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset.
`define ULVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ULVT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ULVT_ASSERT(lbl, prop, msg)

`define ULVT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/ulvt_pkg.sv
// Types and constants shared by the unique value list table modules.
`timescale 1ns / 1ps

package ulvt_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int SIZE_W = 8;

  // Operation codes carried by an input word.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_SIZE   = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SEARCH = 3'd4,
    OP_INSERT = 3'd5,
    OP_DELETE = 3'd6
  } ulvt_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCAN,
    ST_SHIFT,
    ST_CLEAR
  } ulvt_state_e;

  // Kind of result word the datapath assembles.
  typedef enum logic [2:0] {
    RSP_FAIL,
    RSP_CLEAR,
    RSP_SIZE,
    RSP_READ,
    RSP_WRITE,
    RSP_SEARCH,
    RSP_INSERT,
    RSP_DELETE
  } ulvt_resp_e;

  // Input word.
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } ulvt_in_t;

  // Result word.
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         position_out;
    logic                     success;
    logic [SIZE_W-1:0]        size_out;
  } ulvt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       walk;
    logic       shift_wr;
    logic       sweep;
    logic       rd_pos;
    logic       wr_pos;
    logic       ins;
    logic       del_fin;
    logic       clr_cnt;
    logic       resp;
    ulvt_resp_e resp_kind;
  } ulvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic hit;
    logic scan_end;
    logic shift_end;
    logic full;
    logic pos_ok;
  } ulvt_stat_t;

endpackage

// File: design/ulvt_ctrl.sv
// Controller state machine of the unique value list table.
`timescale 1ns / 1ps
`include "unique_value_list_table_defines.svh"

module ulvt_ctrl
  import ulvt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] opcode_i,
  input  ulvt_stat_t      stat_i,
  output ulvt_cmd_t       cmd_o,
  output logic            busy_o
);

  ulvt_state_e     state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;

  // State and latched opcode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      op_q    <= OP_CLEAR;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d = opcode_i;
          case (opcode_i)
            OP_CLEAR:  state_d = ST_CLEAR;
            OP_SEARCH: state_d = ST_SCAN;
            OP_INSERT: state_d = ST_SCAN;
            OP_DELETE: state_d = ST_SCAN;
            default:   state_d = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        if (op_q == OP_READ && stat_i.pos_ok) state_d = ST_RDATA;
        else state_d = ST_IDLE;
      end
      ST_RDATA: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = (op_q == OP_DELETE) ? ST_SHIFT : ST_IDLE;
        end else if (stat_i.scan_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (stat_i.shift_end) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_EXEC: begin
        case (op_q)
          OP_SIZE: begin
            cmd_o.resp      = 1'b1;
            cmd_o.resp_kind = RSP_SIZE;
          end
          OP_READ: begin
            if (stat_i.pos_ok) begin
              cmd_o.rd_pos = 1'b1;
            end else begin
              cmd_o.resp      = 1'b1;
              cmd_o.resp_kind = RSP_FAIL;
            end
          end
          OP_WRITE: begin
            cmd_o.resp = 1'b1;
            if (stat_i.pos_ok) begin
              cmd_o.wr_pos    = 1'b1;
              cmd_o.resp_kind = RSP_WRITE;
            end else begin
              cmd_o.resp_kind = RSP_FAIL;
            end
          end
          default: begin
            cmd_o.resp      = 1'b1;
            cmd_o.resp_kind = RSP_FAIL;
          end
        endcase
      end
      ST_RDATA: begin
        cmd_o.resp      = 1'b1;
        cmd_o.resp_kind = RSP_READ;
      end
      ST_SCAN: begin
        cmd_o.walk = 1'b1;
        if (stat_i.hit) begin
          case (op_q)
            OP_SEARCH: begin
              cmd_o.resp      = 1'b1;
              cmd_o.resp_kind = RSP_SEARCH;
            end
            OP_INSERT: begin
              cmd_o.resp      = 1'b1;
              cmd_o.resp_kind = RSP_FAIL;
            end
            default: begin
              // Delete goes on to close the gap.
              cmd_o.resp = 1'b0;
            end
          endcase
        end else if (stat_i.scan_end) begin
          cmd_o.resp = 1'b1;
          if (op_q == OP_INSERT && !stat_i.full) begin
            cmd_o.ins       = 1'b1;
            cmd_o.resp_kind = RSP_INSERT;
          end else begin
            cmd_o.resp_kind = RSP_FAIL;
          end
        end
      end
      ST_SHIFT: begin
        cmd_o.walk     = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (stat_i.shift_end) begin
          cmd_o.del_fin   = 1'b1;
          cmd_o.resp      = 1'b1;
          cmd_o.resp_kind = RSP_DELETE;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.clr_cnt   = 1'b1;
          cmd_o.resp      = 1'b1;
          cmd_o.resp_kind = RSP_CLEAR;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // A result is issued once per word and never back to back.
  `ULVT_ASSERT(a_resp_single, cmd_o.resp |=> !cmd_o.resp, "result issued twice in a row")

endmodule

// File: design/ulvt_dpath.sv
// Datapath of the unique value list table: entry memory, counters and result register.
`timescale 1ns / 1ps
`include "unique_value_list_table_defines.svh"

module ulvt_dpath
  import ulvt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ulvt_in_t   item_i,
  input  ulvt_cmd_t  cmd_i,
  output ulvt_stat_t stat_o,
  output ulvt_out_t  result_o,
  output logic       done_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;

  logic signed [DATA_W-1:0] val_q;
  logic [POS_W-1:0]         pos_q;
  logic [CW-1:0]            idx_q, idx_d;
  logic                     rv_q, rv_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            where_q;
  ulvt_out_t                res_q, res_d;
  logic                     res_valid_q;

  logic                     idx_lt;
  logic                     hit;
  logic                     full;
  logic                     pos_ok;
  logic [CW-1:0]            idx_m1, idx_m2, cnt_m1;
  logic [AW-1:0]            pos_addr;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     cnt_cmd;

  assign idx_lt   = idx_q < count_q;
  assign idx_m1   = idx_q - CW'(1);
  assign idx_m2   = idx_q - CW'(2);
  assign cnt_m1   = count_q - CW'(1);
  assign hit      = rv_q && (rd_data_q == val_q);
  assign full     = (count_q == CW'(CAPACITY));
  assign pos_ok   = 32'(pos_q) < 32'(CAPACITY);
  assign pos_addr = AW'(pos_q);
  assign cnt_cmd  = cmd_i.ins || cmd_i.del_fin || cmd_i.clr_cnt;

  // Status to the controller.
  always_comb begin
    stat_o.sweep_last = (idx_q == CW'(CAPACITY - 1));
    stat_o.hit        = hit;
    stat_o.scan_end   = !hit && !idx_lt;
    stat_o.shift_end  = !idx_lt && !rv_q;
    stat_o.full       = full;
    stat_o.pos_ok     = pos_ok;
  end

  // Walk pointer: one entry read per cycle; rv marks read data in flight.
  always_comb begin
    idx_d = idx_q;
    rv_d  = 1'b0;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.sweep) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.walk && idx_lt) begin
      idx_d = idx_q + CW'(1);
      rv_d  = 1'b1;
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_cnt) count_d = '0;
    else if (cmd_i.ins) count_d = count_q + CW'(1);
    else if (cmd_i.del_fin) count_d = cnt_m1;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rv_q        <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      count_q     <= count_d;
      res_valid_q <= cmd_i.resp;
    end
  end

  // Latched operands and the position of a match.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= item_i.value;
      pos_q <= item_i.position;
    end
    if (cmd_i.walk && !cmd_i.shift_wr && hit) where_q <= idx_m1;
    if (cmd_i.resp) res_q <= res_d;
  end

  // Single write port: sweep, write by position, append, shift down, tail clear.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cmd_i.sweep) begin
      mem_we = 1'b1;
      mem_wa = idx_q[AW-1:0];
    end else if (cmd_i.wr_pos) begin
      mem_we = 1'b1;
      mem_wa = pos_addr;
      mem_wd = val_q;
    end else if (cmd_i.ins) begin
      mem_we = 1'b1;
      mem_wa = count_q[AW-1:0];
      mem_wd = val_q;
    end else if (cmd_i.shift_wr && rv_q) begin
      // Read data came from idx - 1; it moves one slot down.
      mem_we = 1'b1;
      mem_wa = idx_m2[AW-1:0];
      mem_wd = rd_data_q;
    end else if (cmd_i.del_fin) begin
      mem_we = 1'b1;
      mem_wa = cnt_m1[AW-1:0];
    end
  end

  // Single read port with registered data.
  assign rd_en   = (cmd_i.walk && idx_lt) || cmd_i.rd_pos;
  assign rd_addr = cmd_i.rd_pos ? pos_addr : idx_q[AW-1:0];

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // Result word assembly.
  always_comb begin
    res_d          = '0;
    res_d.size_out = SIZE_W'(count_d);
    case (cmd_i.resp_kind)
      RSP_CLEAR: res_d.success = 1'b1;
      RSP_SIZE:  res_d.success = 1'b1;
      RSP_READ: begin
        res_d.data_out = rd_data_q;
        res_d.success  = 1'b1;
      end
      RSP_WRITE: begin
        res_d.data_out = val_q;
        res_d.success  = 1'b1;
      end
      RSP_SEARCH: begin
        res_d.position_out = POS_W'(idx_m1);
        res_d.success      = 1'b1;
      end
      RSP_INSERT: begin
        res_d.position_out = POS_W'(count_q);
        res_d.success      = 1'b1;
      end
      RSP_DELETE: begin
        res_d.position_out = POS_W'(where_q);
        res_d.success      = 1'b1;
      end
      default: begin
        res_d.success = 1'b0;
      end
    endcase
  end

  assign result_o = res_q;
  assign done_o   = res_valid_q;

  `ULVT_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "count exceeds capacity")
  `ULVT_ASSERT_NEVER(a_ins_full, cmd_i.ins && full, "append into a full table")
  `ULVT_ASSERT_NEVER(a_del_empty, cmd_i.del_fin && (count_q == '0), "delete from empty table")
  `ULVT_ASSERT(a_count_src, (count_q != $past(count_q)) |-> $past(cnt_cmd), "stray count change")

endmodule

// File: design/unique_value_list_table.sv
// Top level of the unique value list table: controller and datapath.
`timescale 1ns / 1ps

//  Channel   Ports                      Handshake
//  command   start, busy, item_i        taken at an edge with start high and busy low
//  result    done_o, result_o           one-cycle strobe, always taken
//
//  Size, write, unused opcodes and reads out of range are answered from the EXEC state, and
//  a read in range from the RDATA state after EXEC; the result register then drives done_o.
//  Search and insert walk the valid entries one per cycle through the memory read port.
//  Delete walks to the match and then shifts later entries down through the same port.
//  Clear and the pass after reset zero one entry per cycle, with busy high.

module unique_value_list_table
  import ulvt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ulvt_in_t  item_i,
  output logic      done_o,
  output ulvt_out_t result_o
);

  ulvt_cmd_t  cmd;
  ulvt_stat_t stat;

  // Sequencing of each operation.
  ulvt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Entry store, count and result register.
  ulvt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// File: verif/ulvt_checker.sv
// Result checker for the unique value list table: predicts each result word and compares.
`timescale 1ns / 1ps

module ulvt_checker
  import ulvt_pkg::*;
#(
  parameter int CAPACITY     = 128,
  parameter int REPORT_LIMIT = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  ulvt_in_t  item_i,
  input  logic      done_i,
  input  ulvt_out_t result_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam int NOT_FOUND = -1;

  // Shadow copy of the table contents and its fill level.
  logic [DATA_W-1:0] entry_mem [CAPACITY];
  int                entry_count;

  // Result words predicted for accepted commands, oldest first.
  ulvt_out_t awaited_results [$];

  initial begin
    foreach (entry_mem[k]) entry_mem[k] = '0;
    entry_count      = 0;
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // Linear search over the valid entries; first match wins.
  function automatic int find_entry(logic [DATA_W-1:0] val);
    for (int k = 0; k < entry_count && k < CAPACITY; k++) begin
      if (entry_mem[k] == val) return k;
    end
    return NOT_FOUND;
  endfunction

  // Applies one command word to the shadow table and returns the result it should give.
  function automatic ulvt_out_t apply_command(ulvt_in_t cmd);
    ulvt_out_t res;
    int        where;
    res = '0;
    case (cmd.opcode)
      OP_CLEAR: begin
        foreach (entry_mem[k]) entry_mem[k] = '0;
        entry_count = 0;
        res.success = 1'b1;
      end
      OP_SIZE: begin
        res.success = 1'b1;
      end
      OP_READ: begin
        if (cmd.position < CAPACITY) begin
          res.data_out = entry_mem[cmd.position];
          res.success  = 1'b1;
        end
      end
      OP_WRITE: begin
        // Writes past the fill level are allowed and leave the count alone.
        if (cmd.position < CAPACITY) begin
          entry_mem[cmd.position] = cmd.value;
          res.data_out            = cmd.value;
          res.success             = 1'b1;
        end
      end
      OP_SEARCH: begin
        where = find_entry(cmd.value);
        if (where != NOT_FOUND) begin
          res.position_out = where[POS_W-1:0];
          res.success      = 1'b1;
        end
      end
      OP_INSERT: begin
        // Duplicates and a full table are refused without any change.
        where = find_entry(cmd.value);
        if (where == NOT_FOUND && entry_count < CAPACITY) begin
          entry_mem[entry_count] = cmd.value;
          res.position_out       = entry_count[POS_W-1:0];
          entry_count++;
          res.success = 1'b1;
        end
      end
      OP_DELETE: begin
        // Close the gap and zero the slot freed at the end.
        where = find_entry(cmd.value);
        if (where != NOT_FOUND) begin
          for (int k = where; k + 1 < entry_count && k + 1 < CAPACITY; k++) begin
            entry_mem[k] = entry_mem[k + 1];
          end
          entry_count--;
          if (entry_count < CAPACITY) entry_mem[entry_count] = '0;
          res.position_out = where[POS_W-1:0];
          res.success      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.size_out = entry_count[SIZE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, ulvt_out_t want, ulvt_out_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t: %s: expected data %h pos %0d ok %0b size %0d",
               $time, what, want.data_out, want.position_out, want.success, want.size_out);
      $display("  got data %h pos %0d ok %0b size %0d",
               got.data_out, got.position_out, got.success, got.size_out);
    end
  endtask

  // Both channels are sampled at the rising edge, before the block's outputs update.
  always @(posedge clk_i) begin
    ulvt_out_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no command pending", '0, result_i);
        end else begin
          want = awaited_results.pop_front();
          if (result_i.data_out !== want.data_out ||
              result_i.position_out !== want.position_out ||
              result_i.success !== want.success ||
              result_i.size_out !== want.size_out) begin
            report_mismatch("result word differs", want, result_i);
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_command(item_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the unique value list table: reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import ulvt_pkg::*;

  localparam int CAPACITY    = 128;
  localparam int NUM_RANDOM  = 1325;
  localparam int FIRST_FILL  = 200;
  localparam int MAX_GAP     = 18;
  localparam int RING_DEPTH  = 128;
  localparam int DRAIN_LIMIT = 5000;
  localparam int QUIET_TAIL  = 300;

  // Opcode that the block does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } mix_e;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ulvt_in_t  item_i;
  logic      done_o;
  ulvt_out_t result_o;
  int        mismatch_count;
  int        pending;

  // Values recently written or inserted, reused so searches and deletes hit.
  logic [DATA_W-1:0] recent_vals [RING_DEPTH];
  int                recent_wr   = 0;
  int                recent_fill = 0;

  unique_value_list_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  ulvt_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .done_i          (done_o),
    .result_i        (result_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #25_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic remember_value(logic [DATA_W-1:0] val);
    recent_vals[recent_wr] = val;
    recent_wr = (recent_wr + 1) % RING_DEPTH;
    if (recent_fill < RING_DEPTH) recent_fill++;
  endtask

  // Mostly values already seen, some corner values, the rest fresh.
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60 && recent_fill > 0) return recent_vals[$urandom_range(0, recent_fill - 1)];
    if (roll < 75) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return '1;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'd1;
      endcase
    end
    return $urandom();
  endfunction

  // Operation mix depends on whether the table should grow, churn or shrink.
  function automatic logic [OP_W-1:0] choose_op(mix_e mode);
    int unsigned     weight [7];
    logic [OP_W-1:0] ops [7];
    int unsigned     roll;
    int unsigned     acc;
    ops = '{OP_INSERT, OP_DELETE, OP_SEARCH, OP_READ, OP_WRITE, OP_SIZE, OP_CLEAR};
    case (mode)
      MIX_FILL:  weight = '{85, 3, 4, 3, 2, 1, 0};
      MIX_CHURN: weight = '{35, 25, 20, 7, 7, 2, 1};
      default:   weight = '{10, 60, 15, 5, 5, 2, 1};
    endcase
    roll = $urandom_range(0, 99);
    acc  = 0;
    for (int i = 0; i < 7; i++) begin
      acc += weight[i];
      if (roll < acc) return ops[i];
    end
    return OP_UNUSED;
  endfunction

  // Optional idle gap, then hold the word until the block takes it.
  // Start is left high on return so back-to-back words need not toggle it.
  task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                       logic [POS_W-1:0] pos, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{opcode: op, value: val, position: pos};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending until every predicted result word has come back.
  task automatic wait_drained(input int limit, output bit drained);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 && waited < limit) begin
      @(negedge clk_i);
      waited++;
    end
    drained = (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    int               sent;
    int               seg;
    int               seg_len;
    mix_e             mode;
    bit               burst;
    bit               drained;
    logic [OP_W-1:0]  op;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0] pos;

    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, corner values, duplicates, deletes at every place.
    issue(OP_SIZE,   32'd0,        7'd0,   1'b0);
    issue(OP_READ,   32'd0,        7'd127, 1'b0);
    issue(OP_SEARCH, 32'd0,        7'd0,   1'b0);
    issue(OP_DELETE, 32'd5,        7'd0,   1'b0);
    issue(OP_INSERT, 32'h8000_0000, 7'd0,  1'b1);
    issue(OP_INSERT, 32'h7FFF_FFFF, 7'd0,  1'b1);
    issue(OP_INSERT, 32'd0,        7'd0,   1'b0);
    issue(OP_INSERT, 32'hFFFF_FFFF, 7'd0,  1'b0);
    issue(OP_INSERT, 32'd0,        7'd0,   1'b0);
    issue(OP_SEARCH, 32'hFFFF_FFFF, 7'd0,  1'b0);
    issue(OP_SEARCH, 32'd12345,    7'd0,   1'b0);
    issue(OP_WRITE,  32'hA5A5_5A5A, 7'd127, 1'b0);
    issue(OP_READ,   32'd0,        7'd127, 1'b1);
    issue(OP_READ,   32'd0,        7'd0,   1'b0);
    issue(OP_DELETE, 32'h7FFF_FFFF, 7'd0,  1'b0);
    issue(OP_READ,   32'd0,        7'd3,   1'b0);
    issue(OP_DELETE, 32'hFFFF_FFFF, 7'd0,  1'b0);
    issue(OP_DELETE, 32'h8000_0000, 7'd0,  1'b0);
    issue(OP_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b0);
    issue(OP_CLEAR,  32'd0,        7'd0,   1'b0);
    issue(OP_READ,   32'd0,        7'd127, 1'b0);
    issue(OP_SIZE,   32'hFFFF_FFFF, 7'd127, 1'b0);
    wait_drained(DRAIN_LIMIT, drained);

    // Random segments; the first one fills the table to capacity and past it.
    sent = 0;
    seg  = 0;
    while (sent < NUM_RANDOM) begin
      seg_len = (seg == 0) ? FIRST_FILL : $urandom_range(60, 180);
      mode    = (seg == 0) ? MIX_FILL : mix_e'($urandom_range(0, 2));
      burst   = ($urandom_range(0, 9) < 3);
      for (int n = 0; n < seg_len && sent < NUM_RANDOM; n++) begin
        op = choose_op(mode);
        if (op == OP_INSERT && mode == MIX_FILL && $urandom_range(0, 9) < 7) begin
          val = $urandom();
        end else begin
          val = pick_value();
        end
        pos = $urandom_range(0, 1) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 15));
        if (op == OP_INSERT || op == OP_WRITE) remember_value(val);
        issue(op, val, pos, burst);
        sent++;
      end
      wait_drained(DRAIN_LIMIT, drained);
      seg++;
    end

    // Final drain, then watch for stray result words.
    wait_drained(DRAIN_LIMIT, drained);
    repeat (QUIET_TAIL) @(posedge clk_i);
    if (mismatch_count == 0 && drained && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
